// File: sv/kbpc_pkg.sv
package kbpc_pkg;

  localparam int KBPC_MAX_KEY_BYTES = 32;

  localparam int KEY_LEN_W = 6;
  localparam int REG_IDX_W = 3;
  localparam int REG_DATA_W = 64;

  localparam logic [REG_IDX_W-1:0] REG_CIPHER_MODE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_LENGTH = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY_BYTES_LOW = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY_BYTES_HIGH = 3'd5;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  localparam logic [14:0] MIX_MULT = 15'd21143;
  localparam logic [30:0] PERM_COUNT = 31'd40320;

  // 8! = 315 << 7, the odd part is reduced by reciprocal multiplication
  localparam logic [8:0]  PERM_ODD = 9'd315;
  localparam logic [24:0] PERM_RECIP = 25'd27269633;
  localparam int          RECIP_SHIFT = 33;

  localparam logic [12:0] FACT_TAB [8] = '{
    13'd1, 13'd1, 13'd2, 13'd6, 13'd24, 13'd120, 13'd720, 13'd5040
  };

  typedef logic [2:0] bit_idx_t;
  typedef bit_idx_t [7:0] perm_t;

  typedef struct packed {
    logic  done;
    perm_t src;
  } perm_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_GEN,
    ST_APPLY
  } kbpc_state_t;

  typedef enum logic [2:0] {
    PG_IDLE,
    PG_MUL,
    PG_QUOT,
    PG_SUB,
    PG_MOD,
    PG_DEC,
    PG_DONE
  } pg_state_t;

  function automatic logic [15:0] fact_mult(input logic [2:0] fi, input logic [2:0] m);
    logic [15:0] f;
    f = 16'(FACT_TAB[fi]);
    return 16'(f * 16'(m));
  endfunction

endpackage

// File: sv/kbpc_key_mem.sv
module kbpc_key_mem import kbpc_pkg::*; #(
  parameter int MAX_KEY_BYTES = KBPC_MAX_KEY_BYTES,
  localparam int ROWS = (MAX_KEY_BYTES + 7) / 8,
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [ROW_W-1:0]      wr_row,
  input  logic [REG_DATA_W-1:0] wr_data,
  input  logic [ROW_W-1:0]      rd_row_a,
  input  logic [ROW_W-1:0]      rd_row_b,
  output logic [REG_DATA_W-1:0] rd_data_a,
  output logic [REG_DATA_W-1:0] rd_data_b
);

  logic [REG_DATA_W-1:0] mem [ROWS];
  logic [ROWS-1:0]       row_valid;
  logic [REG_DATA_W-1:0] q_a;
  logic [REG_DATA_W-1:0] q_b;
  logic                  q_valid_a;
  logic                  q_valid_b;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    q_a <= mem[rd_row_a];
    q_b <= mem[rd_row_b];
  end

  // rows never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      q_valid_a <= 1'b0;
      q_valid_b <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_row] <= 1'b1;
      end
      q_valid_a <= row_valid[rd_row_a];
      q_valid_b <= row_valid[rd_row_b];
    end
  end

  assign rd_data_a = q_valid_a ? q_a : '0;
  assign rd_data_b = q_valid_b ? q_b : '0;

endmodule

// File: sv/kbpc_perm_gen.sv
module kbpc_perm_gen import kbpc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic [7:0] k_byte,
  input  logic [7:0] n_byte,
  output perm_rsp_t rsp
);

  pg_state_t state;
  pg_state_t state_next;

  logic [7:0]  mix_a;
  logic [22:0] mix_t;
  logic [30:0] rem;
  logic [15:0] q_est;
  logic [9:0]  r_raw;
  logic [2:0]  dec_step;
  perm_t       left;
  perm_t       src;

  logic [7:0]  a0;
  logic [22:0] t0;
  logic [48:0] quot_prod;
  logic [24:0] back_prod;
  logic [24:0] r_diff;
  logic [8:0]  r_fold;
  logic [15:0] dec_val;
  logic [2:0]  fidx;
  logic [2:0]  digit;
  logic [2:0]  digit_cnt;
  perm_t       left_next;

  always_comb begin
    a0 = k_byte ^ {n_byte[3:0], n_byte[7:4]};
    t0 = 23'(23'(k_byte ^ a0 ^ n_byte) * 23'(MIX_MULT));
  end

  // quotient estimate is exact or one low, one correction step follows
  always_comb begin
    quot_prod = 49'(rem[30:7]) * 49'(PERM_RECIP);
    back_prod = 25'(q_est) * 25'(PERM_ODD);
    r_diff = 25'(rem[30:7]) - back_prod;
    r_fold = (r_raw >= 10'(PERM_ODD)) ? 9'(r_raw - 10'(PERM_ODD)) : r_raw[8:0];
  end

  // one factorial digit per step
  always_comb begin
    dec_val = rem[15:0];
    fidx = ~dec_step;
    digit_cnt = '0;
    for (int m = 1; m < 8; m++) begin
      if (dec_val >= fact_mult(fidx, 3'(m))) begin
        digit_cnt = digit_cnt + 3'd1;
      end
    end
    digit = (digit_cnt > fidx) ? fidx : digit_cnt;
    left_next = left;
    for (int j = 0; j < 7; j++) begin
      if (3'(j) >= digit) begin
        left_next[j] = left[j+1];
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      PG_IDLE: begin
        if (start) begin
          state_next = PG_MUL;
        end
      end
      PG_MUL: state_next = PG_QUOT;
      PG_QUOT: state_next = PG_SUB;
      PG_SUB: state_next = PG_MOD;
      PG_MOD: state_next = PG_DEC;
      PG_DEC: begin
        if (dec_step == 3'd7) begin
          state_next = PG_DONE;
        end
      end
      PG_DONE: state_next = PG_IDLE;
      default: state_next = PG_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state == PG_DONE);
    rsp.src = src;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      PG_IDLE: begin
        mix_a <= a0;
        mix_t <= t0;
      end
      PG_MUL: begin
        rem <= 31'(31'(mix_a) * 31'(mix_t));
      end
      PG_QUOT: begin
        q_est <= quot_prod[RECIP_SHIFT +: 16];
      end
      PG_SUB: begin
        r_raw <= r_diff[9:0];
      end
      PG_MOD: begin
        rem <= 31'({r_fold, rem[6:0]});
        dec_step <= '0;
        for (int i = 0; i < 8; i++) begin
          left[i] <= 3'(i);
        end
      end
      PG_DEC: begin
        src[dec_step] <= left[digit];
        left <= left_next;
        rem <= 31'(dec_val - fact_mult(fidx, digit));
        dec_step <= dec_step + 3'd1;
      end
      PG_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/keyed_bit_permutation_cipher_unit.sv
// Keyed bit permutation cipher. Each data beat returns one result beat holding the
// data byte with its eight bits permuted; the permutation comes from the key bytes
// at the current key position and the next one, and the position then advances and
// wraps at the key length. The key bytes sit in a row memory read on two ports; the
// permutation index is reduced modulo 8! by a reciprocal multiply, a back-multiply
// and subtract, and one correction step, then decoded one factorial digit per cycle,
// and the next byte is taken only after the result register loads, so a single byte
// is in flight at a time. While an earlier result waits on a stalled receiver, the new
// result holds in its last step and the data input stays stalled. Restart on a data
// beat returns the position to zero, as does any write to a defined register.
// Configuration is to be written only while the block is idle; the block itself
// does not enforce this.
module keyed_bit_permutation_cipher_unit import kbpc_pkg::*; #(
  parameter int MAX_KEY_BYTES = KBPC_MAX_KEY_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  write_enable,
  input  logic [REG_IDX_W-1:0]  register_index,
  input  logic [REG_DATA_W-1:0] write_data,
  input  logic                  data_valid,
  output logic                  data_stall,
  input  logic [7:0]            data_byte,
  input  logic                  restart,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [7:0]            result_byte
);

  localparam int ROWS = (MAX_KEY_BYTES + 7) / 8;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int POS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  kbpc_state_t state;
  kbpc_state_t state_next;

  logic                 cipher_mode;
  logic [KEY_LEN_W-1:0] key_length;
  logic [POS_W-1:0]     key_position;
  logic [7:0]           data_r;
  logic [2:0]           k_off;
  logic [2:0]           n_off;

  logic                 accept;
  logic                 load_result;
  logic                 perm_start;
  logic [KEY_LEN_W-1:0] len_eff;
  logic [KEY_LEN_W-1:0] pos6;
  logic [KEY_LEN_W-1:0] nxt6;
  logic [2:0]           key_row;
  logic                 key_we;
  logic [REG_DATA_W-1:0] rd_data_a;
  logic [REG_DATA_W-1:0] rd_data_b;
  logic [7:0]           k_byte;
  logic [7:0]           n_byte;
  perm_rsp_t            perm_rsp;
  logic [7:0]           permuted;
  logic [7:0]           src_cover;

  assign accept = data_valid && !data_stall;

  always_comb begin
    len_eff = key_length;
    if (key_length == '0) begin
      len_eff = KEY_LEN_W'(1);
    end else if (key_length > KEY_LEN_W'(MAX_KEY_BYTES)) begin
      len_eff = KEY_LEN_W'(MAX_KEY_BYTES);
    end
    pos6 = restart ? '0 : KEY_LEN_W'(key_position);
    if (pos6 >= len_eff) begin
      pos6 = '0;
    end
    nxt6 = pos6 + KEY_LEN_W'(1);
    if (nxt6 >= len_eff) begin
      nxt6 = '0;
    end
  end

  always_comb begin
    key_row = register_index - REG_KEY_BYTES_LOW;
    key_we = write_enable && (register_index >= REG_KEY_BYTES_LOW) &&
             (register_index <= REG_KEY_BYTES_HIGH) && (key_row < 3'(ROWS));
  end

  kbpc_key_mem #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_key_mem (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (key_we),
    .wr_row   (ROW_W'(key_row)),
    .wr_data  (write_data),
    .rd_row_a (pos6[ROW_W+2:3]),
    .rd_row_b (nxt6[ROW_W+2:3]),
    .rd_data_a(rd_data_a),
    .rd_data_b(rd_data_b)
  );

  assign k_byte = rd_data_a[{k_off, 3'b000} +: 8];
  assign n_byte = rd_data_b[{n_off, 3'b000} +: 8];

  kbpc_perm_gen u_perm_gen (
    .clk   (clk),
    .rst   (rst),
    .start (perm_start),
    .k_byte(k_byte),
    .n_byte(n_byte),
    .rsp   (perm_rsp)
  );

  always_comb begin
    permuted = '0;
    src_cover = '0;
    for (int i = 0; i < 8; i++) begin
      src_cover[perm_rsp.src[i]] = 1'b1;
      if (cipher_mode == MODE_ENCRYPT) begin
        permuted[i] = data_r[perm_rsp.src[i]];
      end else if (data_r[i]) begin
        permuted[perm_rsp.src[i]] = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_GEN;
      ST_GEN: begin
        if (perm_rsp.done) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (!result_valid || !result_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    data_stall = (state != ST_IDLE);
    perm_start = (state == ST_READ);
    load_result = (state == ST_APPLY) && (!result_valid || !result_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cipher_mode <= MODE_ENCRYPT;
      key_length <= KEY_LEN_W'(1);
      key_position <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (write_enable && (register_index <= REG_KEY_BYTES_HIGH)) begin
        key_position <= '0;
      end else if (accept) begin
        key_position <= POS_W'(nxt6);
      end
      if (write_enable) begin
        unique case (register_index)
          REG_CIPHER_MODE: cipher_mode <= write_data[0];
          REG_KEY_LENGTH: key_length <= write_data[KEY_LEN_W-1:0];
          default: begin
          end
        endcase
      end
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= data_byte;
      k_off <= pos6[2:0];
      n_off <= nxt6[2:0];
    end
    if (load_result) begin
      result_byte <= permuted;
    end
  end

  a_result_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_APPLY)
    else $error("result beat without a finished permutation");

  a_position_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> KEY_LEN_W'(key_position) < len_eff)
    else $error("key position beyond key length");

  a_done_while_gen: assert property (@(posedge clk) disable iff (rst)
    perm_rsp.done |-> state == ST_GEN)
    else $error("permutation done outside generation");

  a_perm_complete: assert property (@(posedge clk) disable iff (rst)
    perm_rsp.done |-> src_cover == 8'hff)
    else $error("decoded ordering is not a permutation");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import kbpc_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_KEY_BYTES_MID_LOW  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KEY_BYTES_MID_HIGH = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_A            = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B            = 3'd7;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 40;
  localparam int PHASE_ITEMS  = 545;

  logic                  clk;
  logic                  rst;
  logic                  write_enable;
  logic [REG_IDX_W-1:0]  register_index;
  logic [REG_DATA_W-1:0] write_data;
  logic                  data_valid;
  logic                  data_stall;
  logic [7:0]            data_byte;
  logic                  restart;
  logic                  result_valid;
  logic                  result_stall;
  logic [7:0]            result_byte;

  // mirror of the block's registers and key position
  logic                  cur_mode;
  logic [KEY_LEN_W-1:0]  cur_len;
  logic [63:0]           key_words [4];
  logic [4:0]            key_pos;

  logic [7:0]            expected_bytes [$];
  int                    errors;
  int                    snd_idle_pct;
  int                    rcv_idle_pct;
  int                    quiet_cycles;

  keyed_bit_permutation_cipher_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .data_valid     (data_valid),
    .data_stall     (data_stall),
    .data_byte      (data_byte),
    .restart        (restart),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result_byte    (result_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] permute_byte(input logic [7:0] value, input logic rs);
    int unsigned len, pos, nxt, cnt, idx, f, i, j;
    logic [7:0]  k, n, mixed, res;
    logic [31:0] a;
    bit_idx_t    pool [8];
    perm_t       order;
    len = cur_len;
    if (len == 0) len = 1;
    if (len > KBPC_MAX_KEY_BYTES) len = KBPC_MAX_KEY_BYTES;
    if (rs) key_pos = '0;
    pos = key_pos;
    if (pos >= len) pos = 0;
    nxt = pos + 1;
    if (nxt >= len) nxt = 0;
    k = key_words[pos / 8][(pos % 8) * 8 +: 8];
    n = key_words[nxt / 8][(nxt % 8) * 8 +: 8];
    mixed = k ^ {n[3:0], n[7:4]};
    a = 32'(mixed) * (32'(k ^ mixed ^ n) * 32'(MIX_MULT));
    a = a % 32'(PERM_COUNT);
    for (i = 0; i < 8; i++) pool[i] = bit_idx_t'(i);
    cnt = 8;
    // factorial number system decode
    for (i = 0; i < 8; i++) begin
      f = FACT_TAB[7 - i];
      idx = a / f;
      if (idx >= cnt) idx = cnt - 1;
      order[i] = pool[idx];
      for (j = idx; j + 1 < cnt; j++) pool[j] = pool[j + 1];
      cnt--;
      a = a % f;
    end
    res = '0;
    for (i = 0; i < 8; i++) begin
      if (cur_mode == MODE_ENCRYPT) begin
        res[i] = value[order[i]];
      end else if (value[i]) begin
        res[order[i]] = 1'b1;
      end
    end
    key_pos = 5'(nxt);
    return res;
  endfunction

  function automatic logic [63:0] random_key_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual %02h", $time, result_byte);
        errors++;
      end else begin
        logic [7:0] want;
        want = expected_bytes.pop_front();
        if (result_byte !== want) begin
          $display("%0t: result_byte mismatch, expected %02h actual %02h",
                   $time, want, result_byte);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (data_valid && !data_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic rs);
    int gap;
    if ($urandom_range(0, 399) < snd_idle_pct) begin
      gap = $urandom_range(1, 35);
      data_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      data_valid <= 1'b0;
      @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= value;
    restart    <= rs;
    @(posedge clk);
    while (data_stall) @(posedge clk);
    expected_bytes.push_back(permute_byte(value, rs));
  endtask

  task automatic drain_results();
    data_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    drain_results();
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
    write_enable   <= 1'b1;
    register_index <= idx;
    write_data     <= value;
    @(posedge clk);
    write_enable   <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_CIPHER_MODE:        cur_mode = value[0];
      REG_KEY_LENGTH:         cur_len = value[KEY_LEN_W-1:0];
      REG_KEY_BYTES_LOW:      key_words[0] = value;
      REG_KEY_BYTES_MID_LOW:  key_words[1] = value;
      REG_KEY_BYTES_MID_HIGH: key_words[2] = value;
      REG_KEY_BYTES_HIGH:     key_words[3] = value;
      default: ;
    endcase
    if (idx <= REG_KEY_BYTES_HIGH) key_pos = '0;
  endtask

  task automatic set_key_words(input logic [63:0] w0, input logic [63:0] w1,
                               input logic [63:0] w2, input logic [63:0] w3);
    write_reg(REG_KEY_BYTES_LOW, w0);
    write_reg(REG_KEY_BYTES_MID_LOW, w1);
    write_reg(REG_KEY_BYTES_MID_HIGH, w2);
    write_reg(REG_KEY_BYTES_HIGH, w3);
  endtask

  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
  endtask

  task automatic test_cipher_modes();
    wait_idle();
    set_key_words({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
    write_reg(REG_KEY_LENGTH, 64'd32);
    write_reg(REG_CIPHER_MODE, 64'(MODE_ENCRYPT));
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h5a, 1'b0);
    wait_idle();
    write_reg(REG_CIPHER_MODE, 64'(MODE_DECRYPT));
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'ha5, 1'b0);
  endtask

  task automatic test_length_limits();
    // zero length acts as one byte
    wait_idle();
    write_reg(REG_KEY_LENGTH, 64'd0);
    send_byte(8'h3c, 1'b0);
    send_byte(8'hc3, 1'b0);
    // oversized length saturates
    wait_idle();
    write_reg(REG_KEY_LENGTH, 64'd63);
    send_byte(8'h96, 1'b0);
    send_byte(8'h69, 1'b0);
  endtask

  task automatic test_restart();
    wait_idle();
    write_reg(REG_KEY_LENGTH, 64'd3);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b1);
    send_byte(8'h78, 1'b0);
  endtask

  task automatic test_ignored_index();
    wait_idle();
    write_reg(REG_KEY_LENGTH, 64'd5);
    send_byte(8'hf0, 1'b0);
    send_byte(8'h0f, 1'b0);
    wait_idle();
    write_reg(REG_SPARE_A, {$urandom, $urandom});
    send_byte(8'haa, 1'b0);
    send_byte(8'h55, 1'b0);
    wait_idle();
    write_reg(REG_SPARE_B, {$urandom, $urandom});
    send_byte(8'he7, 1'b0);
  endtask

  task automatic reshuffle_setup();
    logic [63:0] value;
    wait_idle();
    if ($urandom_range(0, 1)) write_reg(REG_CIPHER_MODE, {$urandom, $urandom});
    value = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: value[KEY_LEN_W-1:0] = 6'd0;
      1: value[KEY_LEN_W-1:0] = 6'd1;
      2: value[KEY_LEN_W-1:0] = 6'd32;
      3: value[KEY_LEN_W-1:0] = 6'd63;
      4: value[KEY_LEN_W-1:0] = 6'($urandom_range(33, 62));
      5: value[KEY_LEN_W-1:0] = 6'($urandom_range(9, 31));
      default: value[KEY_LEN_W-1:0] = 6'($urandom_range(1, 8));
    endcase
    write_reg(REG_KEY_LENGTH, value);
    if ($urandom_range(0, 1)) write_reg(REG_KEY_BYTES_LOW, random_key_word());
    if ($urandom_range(0, 1)) write_reg(REG_KEY_BYTES_MID_LOW, random_key_word());
    if ($urandom_range(0, 1)) write_reg(REG_KEY_BYTES_MID_HIGH, random_key_word());
    if ($urandom_range(0, 1)) write_reg(REG_KEY_BYTES_HIGH, random_key_word());
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});
    end
  endtask

  task automatic test_random_stream(input int count, input int snd_pct, input int rcv_pct);
    int sent, run;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    sent = 0;
    while (sent < count) begin
      reshuffle_setup();
      run = $urandom_range(4, 60);
      repeat (run) begin
        if ($urandom_range(0, 99) < 3) drain_results();
        send_byte(8'($urandom), $urandom_range(0, 99) < 6);
        sent++;
      end
    end
  endtask

  initial begin
    rst            <= 1'b1;
    write_enable   <= 1'b0;
    register_index <= REG_CIPHER_MODE;
    write_data     <= '0;
    data_valid     <= 1'b0;
    data_byte      <= '0;
    restart        <= 1'b0;
    cur_mode     = MODE_ENCRYPT;
    cur_len      = 6'd1;
    key_words[0] = '0;
    key_words[1] = '0;
    key_words[2] = '0;
    key_words[3] = '0;
    key_pos      = '0;
    snd_idle_pct = 22;
    rcv_idle_pct = 68;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_cipher_modes();
    test_length_limits();
    test_restart();
    test_ignored_index();
    test_random_stream(PHASE_ITEMS, 22, 68);
    test_random_stream(PHASE_ITEMS, 68, 22);
    test_random_stream(PHASE_ITEMS, 0, 0);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
